[hdl/mts_pkg.sv]
// Shared types and constants for the min-tracking stack.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

    localparam int unsigned DATA_W = 32;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Reported for top and minimum while the stack is empty.
    localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd1;

    typedef struct packed {
        logic push;        // push transaction accepted
        logic pop_start;   // pop accepted on a non-empty stack
        logic pop_empty;   // pop accepted on an empty stack
        logic pop_finish;  // read data of a pop is ready
    } t_dp_cmd;

    typedef struct packed {
        logic empty;       // stack holds no elements
    } t_dp_status;

endpackage

`default_nettype wire

[hdl/mts_ctrl.sv]
// Controller of the min-tracking stack: handshake and pop sequencing.
// Depends on mts_pkg for the command and status types.
`timescale 1ns / 1ps
`default_nettype none

module mts_ctrl
    import mts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_mode,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_POP  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic accept;
    logic load_out;

    // The output register must be free, or emptied at this edge, before a new
    // transaction is taken.
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.push       = accept && (i_mode == MODE_PUSH);
        o_cmd.pop_start  = accept && (i_mode == MODE_POP) && !i_status.empty;
        o_cmd.pop_empty  = accept && (i_mode == MODE_POP) && i_status.empty;
        o_cmd.pop_finish = (r_state == ST_POP);
    end

    assign load_out = o_cmd.push || o_cmd.pop_empty || o_cmd.pop_finish;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.pop_start) begin
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[hdl/mts_datapath.sv]
// Datapath of the min-tracking stack: counts, cached top and minimum,
// the value and minimum memories and the result register. Uses mts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mts_datapath
    import mts_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_status                    o_status,
    input  wire logic signed [DATA_W-1:0] i_value,
    output logic signed [DATA_W-1:0]      o_top_value,
    output logic signed [DATA_W-1:0]      o_min_value,
    output logic                          o_is_empty,
    output logic                          o_op_error
);

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    logic signed [DATA_W-1:0] value_mem [STACK_DEPTH];
    logic signed [DATA_W-1:0] min_mem   [STACK_DEPTH];

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_min_count, n_min_count;
    // Cached copies of the top entries of both stores.
    logic signed [DATA_W-1:0] r_top, n_top;
    logic signed [DATA_W-1:0] r_min, n_min;
    logic signed [DATA_W-1:0] r_rd_top;
    logic signed [DATA_W-1:0] r_rd_min;

    logic signed [DATA_W-1:0] r_out_top, n_out_top;
    logic signed [DATA_W-1:0] r_out_min, n_out_min;
    logic r_out_empty, n_out_empty;
    logic r_out_err, n_out_err;

    logic          full;
    logic          take_min;
    logic [CW-1:0] mc_base;
    logic          min_wr;
    logic [CW-1:0] push_mc;
    logic signed [DATA_W-1:0] push_min;
    logic          pop_drops_min;
    logic [CW-1:0] pop_count;
    logic [CW-1:0] pop_mc;
    logic [CW-1:0] top_rd_idx;
    logic [CW-1:0] min_rd_idx;

    assign o_status.empty = (r_count == '0);
    assign full = (r_count == DEPTH_C);

    // Push: the value joins the minimum store when it ties or beats the minimum.
    assign take_min = (r_count == '0) || (r_min_count == '0) || (i_value <= r_min);
    assign mc_base  = (r_count == '0) ? '0 : r_min_count;
    assign min_wr   = take_min && (mc_base < DEPTH_C);
    assign push_mc  = min_wr ? mc_base + ONE_C : r_min_count;
    assign push_min = min_wr ? i_value : r_min;

    // Pop: the minimum entry leaves when it equals the discarded top.
    assign pop_drops_min = (r_min_count != '0) && (r_min == r_top);
    assign pop_count     = r_count - ONE_C;
    assign pop_mc        = (pop_count == '0) ? '0
                         : r_min_count - CW'(pop_drops_min);
    assign top_rd_idx    = pop_count - ONE_C;
    assign min_rd_idx    = pop_mc - ONE_C;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !full) begin
            value_mem[r_count[AW-1:0]] <= i_value;
            if (min_wr) begin
                min_mem[mc_base[AW-1:0]] <= i_value;
            end
        end
        r_rd_top <= value_mem[top_rd_idx[AW-1:0]];
        r_rd_min <= min_mem[min_rd_idx[AW-1:0]];
    end

    always_comb begin
        n_count     = r_count;
        n_min_count = r_min_count;
        n_top       = r_top;
        n_min       = r_min;
        n_out_top   = r_out_top;
        n_out_min   = r_out_min;
        n_out_empty = r_out_empty;
        n_out_err   = r_out_err;
        if (i_cmd.push) begin
            if (!full) begin
                n_count     = r_count + ONE_C;
                n_min_count = push_mc;
                n_top       = i_value;
                n_min       = push_min;
                n_out_top   = i_value;
            end else begin
                n_out_top   = r_top;
            end
            n_out_min   = full ? ((r_min_count == '0) ? EMPTY_MARK : r_min)
                               : ((push_mc == '0) ? EMPTY_MARK : push_min);
            n_out_empty = 1'b0;
            n_out_err   = full;
        end else if (i_cmd.pop_empty) begin
            n_out_top   = EMPTY_MARK;
            n_out_min   = EMPTY_MARK;
            n_out_empty = 1'b1;
            n_out_err   = 1'b1;
        end else if (i_cmd.pop_start) begin
            n_count     = pop_count;
            n_min_count = pop_mc;
        end else if (i_cmd.pop_finish) begin
            n_top       = r_rd_top;
            n_min       = r_rd_min;
            n_out_top   = (r_count == '0) ? EMPTY_MARK : r_rd_top;
            n_out_min   = ((r_count == '0) || (r_min_count == '0)) ? EMPTY_MARK
                                                                  : r_rd_min;
            n_out_empty = (r_count == '0);
            n_out_err   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_min_count <= '0;
        end else begin
            r_count     <= n_count;
            r_min_count <= n_min_count;
        end
        r_top       <= n_top;
        r_min       <= n_min;
        r_out_top   <= n_out_top;
        r_out_min   <= n_out_min;
        r_out_empty <= n_out_empty;
        r_out_err   <= n_out_err;
    end

    assign o_top_value = r_out_top;
    assign o_min_value = r_out_min;
    assign o_is_empty  = r_out_empty;
    assign o_op_error  = r_out_err;

endmodule

`default_nettype wire

[hdl/min_tracking_stack.sv]
// Top level of the min-tracking stack: controller plus datapath.
// Depends on mts_pkg, mts_ctrl and mts_datapath.
//
// Usage:
//   The input channel (i_in_valid / o_in_ready) carries one operation per
//   transaction: i_mode selects push of i_value or pop of the top element.
//   The output channel (o_out_valid / i_out_ready) returns exactly one result
//   per operation: new top, new minimum (-1 when empty), empty and error flags.
//   A push on a full stack or a pop on an empty one is flagged and changes
//   nothing.
// Latency and throughput:
//   A push, and a pop on an empty stack, show their result in the cycle after
//   acceptance, so pushes can run at one per cycle while results are taken.
//   A non-empty pop passes through a pop state that takes no new operation,
//   as the new top and minimum come from each memory's registered read port.
// Reset:
//   The synchronous active-low reset empties the stack and drops any pending
//   result. Memory contents are not cleared; only written entries are read.
// Stalls:
//   The result is held in an output register until taken. A new operation is
//   accepted only when that register is empty or being taken in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module min_tracking_stack
    import mts_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_mode,
    input  wire logic signed [DATA_W-1:0] i_value,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [DATA_W-1:0]      o_top_value,
    output logic signed [DATA_W-1:0]      o_min_value,
    output logic                          o_is_empty,
    output logic                          o_op_error
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    mts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    mts_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_value     (i_value),
        .o_top_value (o_top_value),
        .o_min_value (o_min_value),
        .o_is_empty  (o_is_empty),
        .o_op_error  (o_op_error)
    );

endmodule

`default_nettype wire

[hdl/mts_checker.sv]
// Port-level checks for the min-tracking stack, bound to the top level.
// Depends on mts_pkg and min_tracking_stack.
`timescale 1ns / 1ps
`default_nettype none

module mts_checker
    import mts_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_in_valid,
    input wire logic                     o_in_ready,
    input wire logic                     i_mode,
    input wire logic signed [DATA_W-1:0] i_value,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_ready,
    input wire logic signed [DATA_W-1:0] o_top_value,
    input wire logic signed [DATA_W-1:0] o_min_value,
    input wire logic                     o_is_empty,
    input wire logic                     o_op_error
);

    // An empty stack reports the empty mark for both top and minimum.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |->
            (o_top_value == EMPTY_MARK) && (o_min_value == EMPTY_MARK))
        else $error("empty result without empty marks");

    // The minimum never exceeds the top element.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_empty) |-> (o_min_value <= o_top_value))
        else $error("minimum above top element");

    // A successful push shows the pushed value as the new top in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_mode == MODE_PUSH)) |=>
            o_out_valid && (o_op_error || (o_top_value == $past(i_value))))
        else $error("push result missing or wrong");

    // A stalled result holds.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            o_out_valid && $stable(o_top_value) && $stable(o_min_value))
        else $error("stalled result changed");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_mode      (i_mode),
    .i_value     (i_value),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_top_value (o_top_value),
    .o_min_value (o_min_value),
    .o_is_empty  (o_is_empty),
    .o_op_error  (o_op_error)
);

`default_nettype wire
